[design/cca_pkg.sv]
// -----------------------------------------------------------------------------
// cca_pkg
// Shared types and constants for the colour code assigner: table geometry,
// character codes, request kinds, depth modes and the controller states.
// -----------------------------------------------------------------------------
package cca_pkg;

   localparam int TableEntries = 65536;
   localparam int IndexWidth   = $clog2(TableEntries);
   localparam int KeyWidth     = 16;

   localparam int LetterCount  = 26;
   localparam int SecondCount  = 2 * LetterCount;

   localparam logic [6:0] CharUpperA = 7'd65;
   localparam logic [6:0] CharLowerA = 7'd97;

   localparam logic [4:0] FirstLast  = 5'(LetterCount - 1);
   localparam logic [5:0] SecondLow  = 6'(LetterCount);
   localparam logic [5:0] SecondDone = 6'(SecondCount);

   localparam logic KindAssign = 1'b0;
   localparam logic KindLookup = 1'b1;

   localparam int ModeWordBit   = 0;
   localparam int ModeReduceBit = 1;

   typedef struct packed {
      logic       valid;
      logic [4:0] first;
      logic [5:0] second;
   } entry_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RESOLVE
   } state_type;

endpackage

[design/color_code_assigner.sv]
// -----------------------------------------------------------------------------
// color_code_assigner
// Path: the table read is registered, then the result goes to the output register.
// Throughput: one request per cycle while rsp_tready stays high; a held result
// stalls the table update, with a same-key write forwarded to the next read.
// Reset: synchronous; the key table is then swept clear, one entry a cycle,
// over all 65536 entries, during which req_tready is low. Codes restart at AA.
// -----------------------------------------------------------------------------
module color_code_assigner (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // pixel_value [23:0]
   input  logic        req_tuser,   // kind [0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // code_first_char [6:0], code_second_char [13:7], zeros
   output logic [1:0]  rsp_tuser,   // newly_assigned [0], code_valid [1]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_data
);

   cca_pkg::entry_type code_table [cca_pkg::TableEntries];

   cca_pkg::state_type state_ff, state_in;

   logic [1:0]                      mode_ff;
   logic [cca_pkg::IndexWidth-1:0]  clr_ff, clr_in;
   logic [4:0]                      first_ff, first_in;
   logic [5:0]                      second_ff, second_in;

   logic [cca_pkg::KeyWidth-1:0]    req_key;
   logic                            req_range_ok;
   logic                            req_xfer;

   logic [cca_pkg::IndexWidth-1:0]  idx_ff;
   logic                            kind_ff;
   logic                            range_ok_ff;
   cca_pkg::entry_type              rd_data_ff;
   logic                            fwd_ff;
   cca_pkg::entry_type              fwd_entry_ff;

   cca_pkg::entry_type              cur_entry;
   logic                            res_done;
   logic                            res_valid;
   logic                            res_fresh;
   logic [4:0]                      res_first;
   logic [5:0]                      res_second;

   logic                            mem_we;
   logic [cca_pkg::IndexWidth-1:0]  mem_addr;
   cca_pkg::entry_type              mem_wdata;
   logic                            assign_we;
   logic                            clear_we;

   logic                            rsp_valid_ff;
   logic [6:0]                      rsp_first_ff;
   logic [6:0]                      rsp_second_ff;
   logic                            rsp_fresh_ff;
   logic                            rsp_code_valid_ff;

   always_comb begin
      if (mode_ff[cca_pkg::ModeReduceBit]) begin
         req_key = {req_tdata[7:3], req_tdata[15:10], req_tdata[23:19]};
      end else if (mode_ff[cca_pkg::ModeWordBit]) begin
         req_key = req_tdata[15:0];
      end else begin
         req_key = {8'd0, req_tdata[7:0]};
      end
   end

   assign req_range_ok = ({1'b0, req_key} < 17'(cca_pkg::TableEntries));
   assign req_xfer     = req_tvalid && req_tready;
   assign res_done     = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cca_pkg::ST_CLEAR: begin
            if (clr_ff == cca_pkg::IndexWidth'(cca_pkg::TableEntries - 1)) begin
               state_in = cca_pkg::ST_IDLE;
            end
         end
         cca_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = cca_pkg::ST_RESOLVE;
            end
         end
         cca_pkg::ST_RESOLVE: begin
            if (res_done && !req_tvalid) begin
               state_in = cca_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cca_pkg::ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      clear_we   = 1'b0;
      clr_in     = clr_ff;
      case (state_ff)
         cca_pkg::ST_CLEAR: begin
            clear_we = 1'b1;
            clr_in   = clr_ff + 1'b1;
         end
         cca_pkg::ST_IDLE: begin
            req_tready = 1'b1;
         end
         cca_pkg::ST_RESOLVE: begin
            req_tready = res_done;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   always_comb begin
      cur_entry  = fwd_ff ? fwd_entry_ff : rd_data_ff;
      res_valid  = 1'b0;
      res_fresh  = 1'b0;
      res_first  = cur_entry.first;
      res_second = cur_entry.second;
      first_in   = first_ff;
      second_in  = second_ff;
      assign_we  = 1'b0;
      if (!range_ok_ff) begin
         res_valid = 1'b0;
      end else if (cur_entry.valid) begin
         res_valid = 1'b1;
      end else if (kind_ff == cca_pkg::KindAssign && second_ff != cca_pkg::SecondDone) begin
         res_valid  = 1'b1;
         res_fresh  = 1'b1;
         res_first  = first_ff;
         res_second = second_ff;
         assign_we  = (state_ff == cca_pkg::ST_RESOLVE) && res_done;
         if (assign_we) begin
            if (first_ff == cca_pkg::FirstLast) begin
               first_in  = '0;
               second_in = second_ff + 1'b1;
            end else begin
               first_in = first_ff + 1'b1;
            end
         end
      end
   end

   always_comb begin
      mem_we    = clear_we || assign_we;
      mem_addr  = clear_we ? clr_ff : idx_ff;
      mem_wdata = clear_we ? '0 : {1'b1, first_ff, second_ff};
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         code_table[mem_addr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         rd_data_ff <= code_table[req_key[cca_pkg::IndexWidth-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         idx_ff       <= req_key[cca_pkg::IndexWidth-1:0];
         kind_ff      <= req_tuser;
         range_ok_ff  <= req_range_ok;
         fwd_ff       <= assign_we && (req_key[cca_pkg::IndexWidth-1:0] == idx_ff);
         fwd_entry_ff <= {1'b1, first_ff, second_ff};
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == cca_pkg::ST_RESOLVE) && res_done) begin
         rsp_fresh_ff      <= res_fresh;
         rsp_code_valid_ff <= res_valid;
         if (res_valid) begin
            rsp_first_ff  <= cca_pkg::CharUpperA + 7'(res_first);
            rsp_second_ff <= (res_second < cca_pkg::SecondLow)
                             ? cca_pkg::CharUpperA + 7'(res_second)
                             : cca_pkg::CharLowerA + 7'(res_second - cca_pkg::SecondLow);
         end else begin
            rsp_first_ff  <= '0;
            rsp_second_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cca_pkg::ST_CLEAR;
         clr_ff       <= '0;
         first_ff     <= '0;
         second_ff    <= '0;
         mode_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         first_ff  <= first_in;
         second_ff <= second_in;
         if (csr_valid) begin
            mode_ff <= csr_data;
         end
         if ((state_ff == cca_pkg::ST_RESOLVE) && res_done) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_second_ff, rsp_first_ff};
   assign rsp_tuser  = {rsp_code_valid_ff, rsp_fresh_ff};

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[1]) |-> (rsp_tdata == 16'd0))
      else $error("Invalid result carries non-zero characters.");

   a_fresh_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> rsp_tuser[1])
      else $error("New code reported without a valid code.");

   a_no_req_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cca_pkg::ST_CLEAR) |-> !req_tready)
      else $error("Request taken during the table sweep.");

   a_counter_range: assert property (@(posedge clock) disable iff (reset)
      (first_ff <= cca_pkg::FirstLast) && (second_ff <= cca_pkg::SecondDone))
      else $error("Code counter out of range.");

   a_counter_step: assert property (@(posedge clock) disable iff (reset)
      !$past(assign_we) |-> $stable(first_ff) && $stable(second_ff))
      else $error("Code counter moved without an assignment.");

endmodule
